/* rtl/sbtr_pkg.sv */
package sbtr_pkg;

    // input commands
    typedef enum logic [1:0] {
        CMD_LOAD_ROW   = 2'd0,
        CMD_SET_CURSOR = 2'd1,
        CMD_CHARACTER  = 2'd2,
        CMD_END_STRING = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT,
        ST_REPORT
    } state_t;

    localparam int FIRST_CODE   = 33;
    localparam int GLYPH_ROWS   = 5;
    localparam int MASK_WIDTH   = 60;

    localparam logic [7:0] CODE_NEWLINE = 8'd10;
    localparam logic [7:0] CODE_SPACE   = 8'd32;
    localparam logic [7:0] SCALE_ONE    = 8'd16;

    localparam logic RESULT_GLYPH_ROW = 1'b0;
    localparam logic RESULT_END       = 1'b1;

    localparam logic CFG_SCALE_HORIZONTAL = 1'b0;
    localparam logic CFG_SCALE_VERTICAL   = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic take_item;
        logic read_row;
        logic next_row;
        logic finish_glyph;
        logic emit_report;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic starts_glyph;
        logic starts_report;
        logic last_row;
    } dp_status_t;

endpackage

/* rtl/scaled_bitmap_text_rasterizer.sv */
// channel   signals                                  item
// -------   --------------------------------------   -----------------------------
// in        in_valid, in_stall, command .. origin_y  font load, cursor, char, end
// out       out_valid, out_stall, result_kind ..     glyph pixel row or end report
// cfg       cfg_write_enable, cfg_index, cfg_data    scale register write
//
// load, set cursor, space, newline and skipped codes are taken in ST_IDLE alone
// a printable glyph is taken in ST_IDLE, then each row is a font store read
// (ST_READ) followed by presenting the result (ST_EMIT); rows = ceil(5 * vertical
// scale) capped at the smaller of MAX_SCALE_COLUMNS and 60
// end of string goes to ST_REPORT; out_stall holds the present result in place
// the font store has no reset, cursor and scales reset asynchronously
module scaled_bitmap_text_rasterizer #(
    parameter int GLYPH_COUNT       = 94,
    parameter int MAX_SCALE_COLUMNS = 60
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_enable,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [8:0]  font_row_index,
    input  logic [4:0]  font_row_bits,
    input  logic [7:0]  char_code,
    input  logic [15:0] origin_x,
    input  logic [15:0] origin_y,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic [15:0] pixel_x,
    output logic [15:0] pixel_y,
    output logic [59:0] row_mask,
    output logic [15:0] next_line_y,
    output logic        last_of_run
);
    import sbtr_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    sbtr_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    sbtr_datapath #(
        .GLYPH_COUNT       (GLYPH_COUNT),
        .MAX_SCALE_COLUMNS (MAX_SCALE_COLUMNS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .command          (command),
        .font_row_index   (font_row_index),
        .font_row_bits    (font_row_bits),
        .char_code        (char_code),
        .origin_x         (origin_x),
        .origin_y         (origin_y),
        .cmd              (cmd),
        .status           (status),
        .result_kind      (result_kind),
        .pixel_x          (pixel_x),
        .pixel_y          (pixel_y),
        .row_mask         (row_mask),
        .next_line_y      (next_line_y),
        .last_of_run      (last_of_run)
    );

endmodule

/* rtl/sbtr_controller.sv */
module sbtr_controller (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  sbtr_pkg::dp_status_t  status,
    output sbtr_pkg::ctrl_cmd_t   cmd
);
    import sbtr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (status.starts_glyph)
                    begin
                        state_next = ST_READ;
                    end
                    else if (status.starts_report)
                    begin
                        state_next = ST_REPORT;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_stall)
                begin
                    state_next = status.last_row ? ST_IDLE : ST_READ;
                end
            end
            ST_REPORT:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall         = 1'b1;
        out_valid        = 1'b0;
        cmd              = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall      = 1'b0;
                cmd.take_item = in_valid;
            end
            ST_READ:
            begin
                cmd.read_row = 1'b1;
            end
            ST_EMIT:
            begin
                out_valid        = 1'b1;
                cmd.next_row     = !out_stall && !status.last_row;
                cmd.finish_glyph = !out_stall && status.last_row;
            end
            ST_REPORT:
            begin
                out_valid       = 1'b1;
                cmd.emit_report = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

/* rtl/sbtr_datapath.sv */
module sbtr_datapath #(
    parameter int GLYPH_COUNT       = 94,
    parameter int MAX_SCALE_COLUMNS = 60
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_enable,
    input  logic                 cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic [1:0]           command,
    input  logic [8:0]           font_row_index,
    input  logic [4:0]           font_row_bits,
    input  logic [7:0]           char_code,
    input  logic [15:0]          origin_x,
    input  logic [15:0]          origin_y,
    input  sbtr_pkg::ctrl_cmd_t  cmd,
    output sbtr_pkg::dp_status_t status,
    output logic                 result_kind,
    output logic [15:0]          pixel_x,
    output logic [15:0]          pixel_y,
    output logic [59:0]          row_mask,
    output logic [15:0]          next_line_y,
    output logic                 last_of_run
);
    import sbtr_pkg::*;

    localparam int STORE_ROWS = GLYPH_COUNT * GLYPH_ROWS;
    localparam int ADDR_W     = $clog2(STORE_ROWS);
    localparam int CAP        = (MAX_SCALE_COLUMNS < MASK_WIDTH) ? MAX_SCALE_COLUMNS
                                                                 : MASK_WIDTH;
    localparam int COUNT_W    = $clog2(CAP + 1);
    localparam int CODE_END   = FIRST_CODE + GLYPH_COUNT;

    function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    // ceil(c * s / 16), start of source pixel c
    function automatic logic [6:0] bound(input logic [7:0] s, input logic [2:0] c);
        logic [10:0] t;
        t = {3'b0, s} * {8'b0, c} + 11'd15;
        return t[10:4];
    endfunction

    function automatic logic [COUNT_W-1:0] scaled_count(input logic [7:0] s);
        logic [6:0] n;
        n = bound(s, 3'd5);
        if (n > 7'(CAP))
        begin
            n = 7'(CAP);
        end
        return COUNT_W'(n);
    endfunction

    logic [7:0] scale_h_reg;
    logic [7:0] scale_v_reg;
    logic [7:0] sx;
    logic [7:0] sy;

    logic [15:0] cursor_x_reg;
    logic [15:0] cursor_y_reg;
    logic [15:0] line_start_x_reg;
    logic [ADDR_W-1:0]  base_reg;
    logic [COUNT_W-1:0] row_reg;
    logic [4:0]         rd_bits_reg;

    logic [4:0] font_mem [STORE_ROWS];

    logic [COUNT_W-1:0] nrows;
    logic [COUNT_W-1:0] ncols;
    logic [10:0] adv_x_prod;
    logic [10:0] step_y_prod;
    logic [11:0] line_y_prod;
    logic [15:0] adv_x;
    logic [15:0] step_y;
    logic [15:0] line_y;
    logic        printable;
    logic [2:0]  src_row;
    logic [ADDR_W-1:0] rd_addr;
    logic [11:0] glyph_base;
    logic        load_in_range;
    logic [MASK_WIDTH-1:0] mask;

    assign sx = (scale_h_reg < SCALE_ONE) ? SCALE_ONE : scale_h_reg;
    assign sy = (scale_v_reg < SCALE_ONE) ? SCALE_ONE : scale_v_reg;

    assign nrows = scaled_count(sy);
    assign ncols = scaled_count(sx);

    assign adv_x_prod  = {3'b0, sx} * 11'd6;
    assign step_y_prod = {3'b0, sy} * 11'd6;
    assign line_y_prod = {4'b0, sy} * 12'd12;
    assign adv_x  = {9'b0, adv_x_prod[10:4]};
    assign step_y = {9'b0, step_y_prod[10:4]};
    assign line_y = {8'b0, line_y_prod[11:4]};

    assign printable = ({1'b0, char_code} >= 9'(FIRST_CODE))
                    && ({1'b0, char_code} < 9'(CODE_END));
    assign glyph_base = ({4'b0, char_code} - 12'(FIRST_CODE)) * 12'd5;
    assign load_in_range = (32'(font_row_index) < STORE_ROWS);

    assign status.starts_glyph  = (command == CMD_CHARACTER) && printable;
    assign status.starts_report = (command == CMD_END_STRING);
    assign status.last_row      = (row_reg + COUNT_W'(1)) == nrows;

    // source row is the number of boundaries the output row has passed
    always_comb
    begin
        src_row = 3'd0;
        for (int c = 1; c < GLYPH_ROWS; c++)
        begin
            if ({{(7-COUNT_W){1'b0}}, row_reg} >= bound(sy, 3'(c)))
            begin
                src_row = src_row + 3'd1;
            end
        end
    end

    assign rd_addr = base_reg + ADDR_W'(src_row);

    always_comb
    begin
        logic [2:0] col;
        mask = '0;
        for (int j = 0; j < MASK_WIDTH; j++)
        begin
            col = 3'd0;
            for (int c = 1; c < GLYPH_ROWS; c++)
            begin
                if (7'(j) >= bound(sx, 3'(c)))
                begin
                    col = col + 3'd1;
                end
            end
            mask[j] = rd_bits_reg[col] && (7'(j) < {{(7-COUNT_W){1'b0}}, ncols});
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_item && (command == CMD_LOAD_ROW) && load_in_range)
        begin
            font_mem[ADDR_W'(font_row_index)] <= font_row_bits;
        end
        if (cmd.read_row)
        begin
            rd_bits_reg <= font_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_h_reg <= SCALE_ONE;
            scale_v_reg <= SCALE_ONE;
        end
        else if (cfg_write_enable)
        begin
            if (cfg_index == CFG_SCALE_HORIZONTAL)
            begin
                scale_h_reg <= cfg_data;
            end
            else
            begin
                scale_v_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg     <= '0;
            cursor_y_reg     <= '0;
            line_start_x_reg <= '0;
        end
        else if (cmd.take_item)
        begin
            if (command == CMD_SET_CURSOR)
            begin
                cursor_x_reg     <= origin_x;
                line_start_x_reg <= origin_x;
                cursor_y_reg     <= origin_y;
            end
            else if (command == CMD_CHARACTER)
            begin
                if (char_code == CODE_NEWLINE)
                begin
                    cursor_y_reg <= sat_add(cursor_y_reg, step_y);
                    cursor_x_reg <= line_start_x_reg;
                end
                else if (char_code == CODE_SPACE)
                begin
                    cursor_x_reg <= sat_add(cursor_x_reg, adv_x);
                end
            end
        end
        else if (cmd.finish_glyph)
        begin
            cursor_x_reg <= sat_add(cursor_x_reg, adv_x);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            base_reg <= ADDR_W'(glyph_base);
            row_reg  <= '0;
        end
        else if (cmd.next_row)
        begin
            row_reg <= row_reg + COUNT_W'(1);
        end
    end

    always_comb
    begin
        if (cmd.emit_report)
        begin
            result_kind = RESULT_END;
            pixel_x     = '0;
            pixel_y     = '0;
            row_mask    = '0;
            next_line_y = sat_add(cursor_y_reg, line_y);
            last_of_run = 1'b1;
        end
        else
        begin
            result_kind = RESULT_GLYPH_ROW;
            pixel_x     = cursor_x_reg;
            pixel_y     = sat_add(cursor_y_reg, 16'(row_reg));
            row_mask    = mask;
            next_line_y = '0;
            last_of_run = status.last_row;
        end
    end

endmodule
